FILE: rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way sorted merge core
// Field layouts of the request and result channels, controller states,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // storage geometry
  localparam int MAX_ROWS = 4;
  localparam int MAX_COLS = 16;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int RIDX_W   = $clog2(MAX_ROWS);
  localparam int CUR_W    = $clog2(MAX_COLS + 1);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LEAVES   = 1 << RIDX_W;
  localparam int NODES    = 2 * LEAVES - 1;

  // fixed field widths
  localparam int VAL_W    = 32;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 4;
  localparam int RCNT_W   = 3;
  localparam int RLEN_W   = 5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd1;

  localparam logic [RCNT_W-1:0] ROW_COUNT_RST  = 3'd4;
  localparam logic [RLEN_W-1:0] ROW_LENGTH_RST = 5'd16;

  // request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_MERGE = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] merged_value;
    logic [ROW_W-1:0]        source_row;
    logic [COL_W-1:0]        source_col;
    logic                    last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME_RD,
    ST_PRIME_WR,
    ST_PICK,
    ST_FILL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // write the request value into the store
    logic clear;     // reset cursors, count and selected row
    logic fetch;     // read head of selected row at its cursor
    logic capture;   // latch read data into head of selected row
    logic next_row;  // step selected row during priming
    logic pick;      // emit the minimum head and advance its row
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // configured merge has no elements
    logic prime_last;  // selected row is the last configured row
    logic last_pick;   // next pick emits the final element
  } sts_t;

  // flat store address of a row and column
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [RIDX_W-1:0] r,
                                                  input logic [CUR_W-1:0]  c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage

FILE: rtl/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl: merge sequencer
// Accepts requests while idle, primes the row heads from the store, then
// alternates a pick cycle and a head refill cycle until the merge is done.
// ----------------------------------------------------------------------------
module kwm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            func_i,
  input  kwm_pkg::sts_t   sts_i,
  output logic            busy,
  output kwm_pkg::cmd_t   cmd_o
);

  kwm_pkg::state_t state_r;
  kwm_pkg::state_t state_nxt;
  logic            accept;

  assign accept = start && (state_r == kwm_pkg::ST_IDLE);
  assign busy   = (state_r != kwm_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kwm_pkg::ST_IDLE: begin
        if (accept && (func_i == kwm_pkg::FUNC_MERGE) && !sts_i.empty) begin
          state_nxt = kwm_pkg::ST_PRIME_RD;
        end
      end
      kwm_pkg::ST_PRIME_RD: begin
        state_nxt = kwm_pkg::ST_PRIME_WR;
      end
      kwm_pkg::ST_PRIME_WR: begin
        state_nxt = sts_i.prime_last ? kwm_pkg::ST_PICK : kwm_pkg::ST_PRIME_RD;
      end
      kwm_pkg::ST_PICK: begin
        state_nxt = sts_i.last_pick ? kwm_pkg::ST_IDLE : kwm_pkg::ST_FILL;
      end
      kwm_pkg::ST_FILL: begin
        state_nxt = kwm_pkg::ST_PICK;
      end
      default: begin
        state_nxt = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_r)
      kwm_pkg::ST_IDLE: begin
        cmd_o.load  = accept && (func_i == kwm_pkg::FUNC_LOAD);
        cmd_o.clear = accept && (func_i == kwm_pkg::FUNC_MERGE);
      end
      kwm_pkg::ST_PRIME_RD: begin
        cmd_o.fetch = 1'b1;
      end
      kwm_pkg::ST_PRIME_WR: begin
        cmd_o.capture  = 1'b1;
        cmd_o.next_row = !sts_i.prime_last;
      end
      kwm_pkg::ST_PICK: begin
        cmd_o.pick = 1'b1;
      end
      kwm_pkg::ST_FILL: begin
        cmd_o.capture = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath: element store, row cursors, head registers and min tree
// Holds the configuration, the 64-entry store with registered read, one
// head register per row and a compare tree that picks the smallest head.
// ----------------------------------------------------------------------------
module kwm_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kwm_pkg::cmd_t                    cmd_i,
  output kwm_pkg::sts_t                    sts_o,
  input  kwm_pkg::in_t                     in_data_i,
  input  logic                             cfg_we_i,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kwm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                             out_valid_o,
  output kwm_pkg::out_t                    out_data_o
);

  // configuration and effective sizes
  logic [kwm_pkg::RCNT_W-1:0] row_count_r;
  logic [kwm_pkg::RLEN_W-1:0] row_length_r;
  logic [kwm_pkg::RCNT_W-1:0] eff_rows;
  logic [kwm_pkg::RLEN_W-1:0] eff_cols;
  logic [kwm_pkg::CNT_W-1:0]  total;

  // merge state
  logic [kwm_pkg::CUR_W-1:0]        cursor_r [kwm_pkg::MAX_ROWS];
  logic [kwm_pkg::CNT_W-1:0]        count_r;
  logic [kwm_pkg::RIDX_W-1:0]       sel_row_r;
  logic signed [kwm_pkg::VAL_W-1:0] head_r [kwm_pkg::MAX_ROWS];
  logic [kwm_pkg::MAX_ROWS-1:0]     active;

  // store
  logic signed [kwm_pkg::VAL_W-1:0] mem [kwm_pkg::DEPTH];
  logic signed [kwm_pkg::VAL_W-1:0] rd_data_r;
  logic [kwm_pkg::ADDR_W-1:0]       waddr;
  logic [kwm_pkg::ADDR_W-1:0]       raddr;
  logic                             load_en;
  logic                             rd_en;

  // min tree
  logic signed [kwm_pkg::VAL_W-1:0] node_val [kwm_pkg::NODES];
  logic [kwm_pkg::RIDX_W-1:0]       node_row [kwm_pkg::NODES];
  logic                             node_ok  [kwm_pkg::NODES];
  logic signed [kwm_pkg::VAL_W-1:0] win_val;
  logic [kwm_pkg::RIDX_W-1:0]       win_row;
  logic                             win_ok;

  kwm_pkg::out_t out_r;
  logic          out_valid_r;

  // clamp configuration to the store size
  assign eff_rows = (int'(row_count_r) > kwm_pkg::MAX_ROWS)
                  ? kwm_pkg::RCNT_W'(kwm_pkg::MAX_ROWS) : row_count_r;
  assign eff_cols = (int'(row_length_r) > kwm_pkg::MAX_COLS)
                  ? kwm_pkg::RLEN_W'(kwm_pkg::MAX_COLS) : row_length_r;
  assign total    = kwm_pkg::CNT_W'(int'(eff_rows) * int'(eff_cols));

  // rows that still hold elements
  always_comb begin
    for (int i = 0; i < kwm_pkg::MAX_ROWS; i++) begin
      active[i] = (i < int'(eff_rows)) && (int'(cursor_r[i]) < int'(eff_cols));
    end
  end

  // status
  assign sts_o.empty      = (total == '0);
  assign sts_o.prime_last = (int'(sel_row_r) + 1 == int'(eff_rows));
  assign sts_o.last_pick  = (int'(count_r) + 1 == int'(total));

  // store ports
  assign load_en = cmd_i.load
                && (int'(in_data_i.row) < int'(eff_rows))
                && (int'(in_data_i.col) < int'(eff_cols));
  assign waddr   = kwm_pkg::elem_addr(kwm_pkg::RIDX_W'(in_data_i.row),
                                      kwm_pkg::CUR_W'(in_data_i.col));
  assign rd_en   = cmd_i.fetch || cmd_i.pick;
  assign raddr   = cmd_i.pick
                 ? kwm_pkg::elem_addr(win_row, cursor_r[win_row] + 1'b1)
                 : kwm_pkg::elem_addr(sel_row_r, cursor_r[sel_row_r]);

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[waddr] <= in_data_i.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  // compare tree, ties go to the lower row
  always_comb begin
    for (int i = 0; i < kwm_pkg::LEAVES; i++) begin
      if (i < kwm_pkg::MAX_ROWS) begin
        node_ok[kwm_pkg::LEAVES-1+i]  = active[i];
        node_val[kwm_pkg::LEAVES-1+i] = head_r[i];
      end else begin
        node_ok[kwm_pkg::LEAVES-1+i]  = 1'b0;
        node_val[kwm_pkg::LEAVES-1+i] = '0;
      end
      node_row[kwm_pkg::LEAVES-1+i] = kwm_pkg::RIDX_W'(i);
    end
    for (int n = kwm_pkg::LEAVES - 2; n >= 0; n--) begin
      if (node_ok[2*n+1] && !(node_ok[2*n+2] && (node_val[2*n+2] < node_val[2*n+1]))) begin
        node_ok[n]  = 1'b1;
        node_val[n] = node_val[2*n+1];
        node_row[n] = node_row[2*n+1];
      end else begin
        node_ok[n]  = node_ok[2*n+2];
        node_val[n] = node_val[2*n+2];
        node_row[n] = node_row[2*n+2];
      end
    end
  end

  assign win_ok  = node_ok[0];
  assign win_val = node_val[0];
  assign win_row = node_row[0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  <= kwm_pkg::ROW_COUNT_RST;
      row_length_r <= kwm_pkg::ROW_LENGTH_RST;
      count_r      <= '0;
      sel_row_r    <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < kwm_pkg::MAX_ROWS; i++) begin
        cursor_r[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          kwm_pkg::REG_ROW_COUNT:  row_count_r  <= cfg_wdata_i[kwm_pkg::RCNT_W-1:0];
          kwm_pkg::REG_ROW_LENGTH: row_length_r <= cfg_wdata_i[kwm_pkg::RLEN_W-1:0];
          default: ;
        endcase
      end
      out_valid_r <= cmd_i.pick;
      if (cmd_i.clear) begin
        count_r   <= '0;
        sel_row_r <= '0;
        for (int i = 0; i < kwm_pkg::MAX_ROWS; i++) begin
          cursor_r[i] <= '0;
        end
      end else if (cmd_i.pick) begin
        count_r           <= count_r + 1'b1;
        sel_row_r         <= win_row;
        cursor_r[win_row] <= cursor_r[win_row] + 1'b1;
      end else if (cmd_i.next_row) begin
        sel_row_r <= sel_row_r + 1'b1;
      end
    end
  end

  // head and result payload
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      head_r[sel_row_r] <= rd_data_r;
    end
    if (cmd_i.pick) begin
      out_r.merged_value <= win_val;
      out_r.source_row   <= kwm_pkg::ROW_W'(win_row);
      out_r.source_col   <= kwm_pkg::COL_W'(cursor_r[win_row]);
      out_r.last         <= sts_o.last_pick;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

  // a pick always finds a live row
  a_pick_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pick |-> win_ok)
    else $error("pick with no active row");

  // never emit more than the configured element count
  a_pick_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pick |-> (count_r < total))
    else $error("pick beyond element count");

  // a head capture follows a store read
  a_capture_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.capture |-> $past(rd_en))
    else $error("head captured without a read");

  // the last result is followed by a gap
  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |=> !out_valid_r)
    else $error("result after last");

endmodule

FILE: rtl/k_way_sorted_merge_core.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core: merges up to four ascending lists into one stream
// Usage: a request is taken on a rising edge with start high and busy low.
// A load request (func 0) writes value at (row, col) and gives
// no result; loads outside the configured rows or columns are dropped.
// A merge request (func 1) emits every stored element of the configured
// lists in ascending order, lower row first on equal values, each result
// on out_data for one cycle with out_valid high; last marks the final one.
// After a merge is taken, each row head is read from the store and captured,
// then results follow, one per pick, with a refill of the emitting row's head
// from the store's registered read port between picks. Busy stays high for
// the whole merge; a load leaves busy low.
// The receiver cannot stall: results must be taken when shown.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written while idle;
// the core itself does not enforce this.
// Reset sets row_count to 4 and row_length to 16 and clears the sequencer;
// the store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  kwm_pkg::in_t                   in_data,
  output logic                           out_valid,
  output kwm_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  kwm_pkg::cmd_t cmd;
  kwm_pkg::sts_t sts;

  // sequencer
  kwm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func_i (in_data.func),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // store and merge datapath
  kwm_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

endmodule

FILE: verif/k_way_sorted_merge_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core_tb: self-checking bench of the k-way merge core
// A short table of directed requests covers the value extremes, ties,
// dropped loads, empty merges and clamped register values. Random phases
// follow: each sets new list sizes, loads ascending lists with random
// content in random order, mixes in stray loads, then merges. Every result
// is checked against a table entry or an in-bench merge predictor.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core_tb;
  import kwm_pkg::*;

  localparam int RAND_ITEMS    = 125;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DIR_STEPS     = 26;

  typedef enum bit {STEP_CFG, STEP_REQ} step_kind_t;

  typedef struct {
    step_kind_t               kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    in_t                      req;
    bit                       typed;
    out_t                     want;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // merge predictor state
  logic signed [VAL_W-1:0] elem_store [DEPTH];
  logic [RCNT_W-1:0]       row_count_q;
  logic [RLEN_W-1:0]       row_length_q;
  out_t                    merged_q [$];

  int    errors     = 0;
  int    cycles     = 0;
  int    idle_pct   = 0;
  int    rand_items = 0;
  step_t dir_steps [DIR_STEPS];

  k_way_sorted_merge_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("k_way_sorted_merge_core regression: fail");
      $finish;
    end
  end

  // effective list count and length after clamping
  function automatic int used_rows();
    return (row_count_q > MAX_ROWS) ? MAX_ROWS : int'(row_count_q);
  endfunction

  function automatic int used_cols();
    return (row_length_q > MAX_COLS) ? MAX_COLS : int'(row_length_q);
  endfunction

  // load updates the store, merge queues the whole merged stream
  function automatic void predict_merge(in_t req);
    int   rows, cols, total, emitted, best, r;
    int   cursor [MAX_ROWS];
    out_t res;
    rows = used_rows();
    cols = used_cols();
    total = rows * cols;
    if (req.func == FUNC_LOAD) begin
      if (req.row < rows && req.col < cols)
        elem_store[int'(req.row) * MAX_COLS + int'(req.col)] = req.value;
      return;
    end
    for (r = 0; r < MAX_ROWS; r++) cursor[r] = 0;
    emitted = 0;
    while (emitted < total) begin
      best = -1;
      // strict less keeps the lower row on ties
      for (r = 0; r < rows; r++) begin
        if (cursor[r] < cols && (best < 0 ||
            $signed(elem_store[r * MAX_COLS + cursor[r]]) <
            $signed(elem_store[best * MAX_COLS + cursor[best]])))
          best = r;
      end
      res.merged_value = elem_store[best * MAX_COLS + cursor[best]];
      res.source_row   = ROW_W'(best);
      res.source_col   = COL_W'(cursor[best]);
      cursor[best]++;
      emitted++;
      res.last = (emitted == total);
      merged_q = {merged_q, res};
    end
  endfunction

  // one request, with an optional random gap before it
  task automatic send_request(in_t req, bit predicted);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predicted) predict_merge(req);
  endtask

  // hold off until every expected result is in and the core is idle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (merged_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_COUNT) row_count_q = val[RCNT_W-1:0];
    else row_length_q = val[RLEN_W-1:0];
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (merged_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %0d row %0d col %0d last %0b", $time,
                 out_data.merged_value, out_data.source_row, out_data.source_col,
                 out_data.last);
      end else begin
        want = merged_q.pop_front();
        if (out_data.merged_value !== want.merged_value ||
            out_data.source_row !== want.source_row ||
            out_data.source_col !== want.source_col ||
            out_data.last !== want.last) begin
          errors++;
          $display("%0t: expected value %0d row %0d col %0d last %0b", $time,
                   want.merged_value, want.source_row, want.source_col, want.last);
          $display("%0t: actual   value %0d row %0d col %0d last %0b", $time,
                   out_data.merged_value, out_data.source_row, out_data.source_col,
                   out_data.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    int   ph, r, rc, rl, er, ec;
    int   vals [$];
    in_t  fills [$];
    in_t  req;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    row_count_q  = ROW_COUNT_RST;
    row_length_q = ROW_LENGTH_RST;
    foreach (elem_store[i]) elem_store[i] = '0;

    // single element lists: value extremes, dropped loads, empty merges,
    // then clamped row count with ties across rows
    dir_steps = '{
      '{STEP_CFG, REG_ROW_COUNT, 5'd1, '0, 1'b0, '0},
      '{STEP_CFG, REG_ROW_LENGTH, 5'd1, '0, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd0, 32'sh7fffffff},
        1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd0, 4'd0, 32'sd0},
        1'b1, '{32'sh7fffffff, 2'd0, 4'd0, 1'b1}},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd0, 32'sh80000000},
        1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd3, 4'd15, 32'shffffffff},
        1'b1, '{32'sh80000000, 2'd0, 4'd0, 1'b1}},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd1, 4'd0, 32'sd5}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd1, 32'sd6}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd0, 4'd0, 32'sd0},
        1'b1, '{32'sh80000000, 2'd0, 4'd0, 1'b1}},
      '{STEP_CFG, REG_ROW_COUNT, 5'd0, '0, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd0, 32'sd1}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd0, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CFG, REG_ROW_COUNT, 5'd1, '0, 1'b0, '0},
      '{STEP_CFG, REG_ROW_LENGTH, 5'd0, '0, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd0, 4'd0, 32'sd0}, 1'b0, '0},
      '{STEP_CFG, REG_ROW_COUNT, 5'd7, '0, 1'b0, '0},
      '{STEP_CFG, REG_ROW_LENGTH, 5'd2, '0, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd0, -32'sd5}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd1, 4'd0, -32'sd5}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd2, 4'd0, -32'sd5}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd3, 4'd0, -32'sd7}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd0, 4'd1, 32'sd0}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd1, 4'd1, -32'sd5}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd2, 4'd1, 32'sh7fffffff},
        1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_LOAD, 2'd3, 4'd1, 32'sd0}, 1'b0, '0},
      '{STEP_REQ, REG_ROW_COUNT, 5'd0, '{FUNC_MERGE, 2'd2, 4'd9, 32'sd0}, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) begin
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        send_request(dir_steps[i].req, !dir_steps[i].typed);
        if (dir_steps[i].typed) merged_q = {merged_q, dir_steps[i].want};
      end
    end

    // random phases: new sizes, ascending lists loaded in random order, merge
    for (ph = 0; rand_items < RAND_ITEMS; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 47 : 7;
      if (ph == 2) begin
        rc = 7;
        rl = 31;
      end else if ($urandom_range(7) == 0) begin
        // one register at zero, the other anywhere
        if ($urandom_range(1)) begin
          rc = 0;
          rl = $urandom_range(31);
        end else begin
          rc = $urandom_range(7);
          rl = 0;
        end
      end else begin
        rc = $urandom_range(1, 7);
        rl = $urandom_range(1, 4);
      end
      write_reg(REG_ROW_COUNT, CFG_DATA_W'(rc));
      write_reg(REG_ROW_LENGTH, CFG_DATA_W'(rl));
      er = used_rows();
      ec = used_cols();

      // sorted lists, narrow value range now and then to force ties
      fills = {};
      for (r = 0; r < er; r++) begin
        vals = {};
        repeat (ec) begin
          if ($urandom_range(2) == 0) vals = {vals, int'($urandom_range(6)) - 3};
          else vals = {vals, int'($urandom)};
        end
        vals.sort();
        foreach (vals[c]) begin
          req.func  = FUNC_LOAD;
          req.row   = ROW_W'(r);
          req.col   = COL_W'(c);
          req.value = vals[c];
          fills = {fills, req};
        end
      end
      fills.shuffle();

      foreach (fills[i]) begin
        // stray load anywhere, in range or not
        if ($urandom_range(9) == 0) begin
          req = '{FUNC_LOAD, ROW_W'($urandom), COL_W'($urandom), $urandom};
          send_request(req, 1'b1);
        end
        send_request(fills[i], 1'b1);
        rand_items++;
      end
      req = '{FUNC_MERGE, ROW_W'($urandom), COL_W'($urandom), $urandom};
      send_request(req, 1'b1);
      rand_items++;

      // overwrite a few entries and merge again
      if (ph % 4 == 1 || $urandom_range(1)) begin
        if (ph % 4 == 1) wait_idle();
        if (er > 0 && ec > 0) begin
          repeat ($urandom_range(1, 3)) begin
            req = '{FUNC_LOAD, ROW_W'($urandom_range(er - 1)),
                    COL_W'($urandom_range(ec - 1)), $urandom};
            send_request(req, 1'b1);
            rand_items++;
          end
        end
        req = '{FUNC_MERGE, ROW_W'($urandom), COL_W'($urandom), $urandom};
        send_request(req, 1'b1);
        rand_items++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("k_way_sorted_merge_core regression: pass");
    end else begin
      $display("k_way_sorted_merge_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/kwm_pkg.sv
rtl/kwm_ctrl.sv
rtl/kwm_datapath.sv
rtl/k_way_sorted_merge_core.sv
verif/k_way_sorted_merge_core_tb.sv
